FILE: sv/assert_macros.svh
// assertion macros shared by the voiced median filter rtl
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define VMF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define VMF_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define VMF_ASSERT(name, clk, rst_n, prop)
`define VMF_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

FILE: sv/vmf_pkg.sv
// constants, types and helpers of the voiced median filter
// no dependencies; used by every other file of the block but assert_macros.svh
package vmf_pkg;

  localparam int unsigned MAX_WINDOW = 15;
  localparam int unsigned MAX_ODD    = (MAX_WINDOW - 1) | 1;
  localparam int unsigned HALF_MAX   = MAX_WINDOW / 2;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned WS_W      = 4;
  localparam int unsigned ADDR_W    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
  localparam int unsigned CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_WINDOW);
  localparam int unsigned HALF_W    = $clog2(HALF_MAX + 1);

  localparam int unsigned APB_DW    = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = REG_IDX_W'(0);
  localparam logic [WS_W-1:0]      WS_RESET        = WS_W'(5);

  typedef logic [SAMPLE_W-1:0] sample_t;

  // request bundle from the sequencer to the window memory
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    sample_t           wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              clr;
  } mem_req_t;

  typedef struct packed {
    logic clr;
    logic ins;
  } sort_ctl_t;

  // half width of the effective odd window, window size must be nonzero
  function automatic logic [HALF_W-1:0] eff_half(input logic [WS_W-1:0] ws);
    logic [WS_W-1:0] w;
    w = ws | WS_W'(1);
    if (int'(w) > int'(MAX_ODD)) w = WS_W'(MAX_ODD);
    return HALF_W'(w >> 1);
  endfunction

endpackage

FILE: sv/vmf_if.sv
// stream interfaces of the voiced median filter: input and result channels
// depends on vmf_pkg
interface vmf_in_if import vmf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface vmf_out_if import vmf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t smoothed;
  logic    last_res;

  modport source (output valid, output smoothed, output last_res, input ready);
  modport sink (input valid, input smoothed, input last_res, output ready);
endinterface

FILE: sv/vmf_window_mem.sv
// sample window store: one-write one-read ram with registered read data
// per-entry valid bits make unwritten entries read as zero; depends on vmf_pkg
module vmf_window_mem import vmf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output sample_t  rd_data_o
);

  sample_t              mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  sample_t              rd_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: sv/vmf_rank_sort.sv
// insertion sorter: keeps the voiced samples of one window in ascending order
// one sample per beat, median picked from the sorted row; depends on vmf_pkg
module vmf_rank_sort import vmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sort_ctl_t ctl_i,
  input  sample_t   din_i,
  output sample_t   median_o
);

  sample_t                s_q [MAX_WINDOW];
  sample_t                s_d [MAX_WINDOW];
  logic [CNT_W-1:0]       n_q;
  logic [MAX_WINDOW-1:0]  gt;
  logic                   ins_ok;
  logic [IDX_W-1:0]       mid;
  logic [IDX_W-1:0]       mid_lo;
  logic [SAMPLE_W:0]      sum;

  // unvoiced samples do not take part
  assign ins_ok = ctl_i.ins && (din_i != '0);

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      gt[i] = (CNT_W'(i) < n_q) && (s_q[i] > din_i);
    end
    s_d[0] = (gt[0] || n_q == '0) ? din_i : s_q[0];
    for (int i = 1; i < MAX_WINDOW; i++) begin
      if (gt[i-1]) begin
        s_d[i] = s_q[i-1];
      end else if (gt[i] || CNT_W'(i) == n_q) begin
        s_d[i] = din_i;
      end else begin
        s_d[i] = s_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_ok) begin
      s_q <= s_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (ctl_i.clr) begin
      n_q <= '0;
    end else if (ins_ok) begin
      n_q <= n_q + CNT_W'(1);
    end
  end

  assign mid    = IDX_W'(n_q >> 1);
  assign mid_lo = mid - IDX_W'(1);
  assign sum    = {1'b0, s_q[mid_lo]} + {1'b0, s_q[mid]};

  // even count: mean of the two middle values, truncated
  always_comb begin
    if (n_q == '0) begin
      median_o = '0;
    end else if (n_q[0]) begin
      median_o = s_q[mid];
    end else begin
      median_o = sum[SAMPLE_W:1];
    end
  end

endmodule

FILE: sv/vmf_apb_regs.sv
// apb configuration register: window size
// depends on vmf_pkg
module vmf_apb_regs import vmf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [WS_W-1:0]    window_size_o
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_beat;
  logic [WS_W-1:0]      ws_q;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_beat = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= WS_RESET;
    end else if (wr_beat && reg_idx == REG_WINDOW_SIZE) begin
      ws_q <= pwdata[WS_W-1:0];
    end
  end

  assign prdata        = (reg_idx == REG_WINDOW_SIZE) ? APB_DW'(ws_q) : '0;
  assign window_size_o = ws_q;

endmodule

FILE: sv/voiced_median_filter.sv
// voiced median filter top: a frame that yields a result reads the window ram once
// per slot of W (the effective odd window, at most 15), then passes through a drain
// and an emit state; a frame without result goes straight back to idle.
// a last frame adds one pass per pending output at centre age c, reading ages 0 to
// c + W/2; pass-through has its own state; a stalled result holds the emit or pass state.
// reset clears ram valid bits, warmup count and handshake state at once; window_size 5
`include "assert_macros.svh"

module voiced_median_filter import vmf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  vmf_in_if.sink             in_i,
  vmf_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_EMIT  = 5'b01000,
    S_PASS  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [HALF_W-1:0] warm_q, warm_d;
  logic [HALF_W-1:0] h_q, h_d;
  logic [HALF_W-1:0] c_q, c_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic              last_q, last_d;
  sample_t           pass_q, pass_d;
  logic              feed_q;

  logic              out_valid_q;
  sample_t           out_smoothed_q, out_smoothed_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;

  logic [WS_W-1:0]   window_size;
  logic [HALF_W-1:0] h_in;
  logic              in_acc;
  logic [ADDR_W-1:0] hi;
  mem_req_t          mem_req;
  sort_ctl_t         sort_ctl;
  sample_t           rd_data;
  sample_t           median;

  vmf_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .window_size_o (window_size)
  );

  vmf_window_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  vmf_rank_sort u_sort (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (sort_ctl),
    .din_i    (rd_data),
    .median_o (median)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign h_in       = eff_half(window_size);
  // last age read for the current centre, window never reaches below age 0
  assign hi         = ADDR_W'(c_q) + ADDR_W'(h_q);
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    warm_d         = warm_q;
    h_d            = h_q;
    c_d            = c_q;
    k_d            = k_q;
    last_d         = last_q;
    pass_d         = pass_q;
    out_load       = 1'b0;
    out_smoothed_d = out_smoothed_q;
    out_last_d     = out_last_q;

    mem_req         = '0;
    mem_req.wr_addr = head_q + ADDR_W'(1);
    mem_req.wr_data = in_i.sample;
    mem_req.rd_addr = head_q - k_q;
    sort_ctl        = '0;
    sort_ctl.ins    = feed_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d = in_i.last;
          if (window_size == '0) begin
            pass_d  = in_i.sample;
            state_d = S_PASS;
            if (in_i.last) begin
              mem_req.clr = 1'b1;
              warm_d      = '0;
            end
          end else begin
            mem_req.wr_en = 1'b1;
            head_d        = head_q + ADDR_W'(1);
            h_d           = h_in;
            k_d           = '0;
            if (in_i.last) begin
              c_d          = (warm_q < h_in) ? warm_q : h_in;
              sort_ctl.clr = 1'b1;
              state_d      = S_READ;
            end else begin
              if (warm_q < HALF_W'(HALF_MAX)) begin
                warm_d = warm_q + HALF_W'(1);
              end
              if (warm_q >= h_in) begin
                c_d          = h_in;
                sort_ctl.clr = 1'b1;
                state_d      = S_READ;
              end
            end
          end
        end
      end
      S_READ: begin
        mem_req.rd_en = 1'b1;
        k_d           = k_q + ADDR_W'(1);
        if (k_q == hi) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read beat lands in the sorter
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_smoothed_d = median;
          out_last_d     = last_q && (c_q == '0);
          if (last_q && c_q != '0) begin
            c_d          = c_q - HALF_W'(1);
            k_d          = '0;
            sort_ctl.clr = 1'b1;
            state_d      = S_READ;
          end else begin
            if (last_q) begin
              mem_req.clr = 1'b1;
              warm_d      = '0;
            end
            state_d = S_IDLE;
          end
        end
      end
      S_PASS: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_smoothed_d = pass_q;
          out_last_d     = last_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      warm_q      <= '0;
      feed_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      warm_q  <= warm_d;
      feed_q  <= (state_q == S_READ);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q            <= h_d;
    c_q            <= c_d;
    k_q            <= k_d;
    last_q         <= last_d;
    pass_q         <= pass_d;
    out_smoothed_q <= out_smoothed_d;
    out_last_q     <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.smoothed = out_smoothed_q;
  assign out_o.last_res = out_last_q;

  `VMF_ASSERT(a_read_in_window, clk_i, rst_ni, (state_q == S_READ) |-> (k_q <= hi))
  `VMF_ASSERT(a_centre_in_half, clk_i, rst_ni, (state_q == S_EMIT) |-> (c_q <= h_q))
  `VMF_ASSERT(a_flush_clears, clk_i, rst_ni, (out_load && out_last_d) |=> (warm_q == '0))
  `VMF_ASSERT_NEVER(a_feed_outside_pass, clk_i, rst_ni, feed_q && (state_q == S_IDLE || state_q == S_PASS))

endmodule
